// ===== hdl/qfir_pkg.sv =====
package qfir_pkg;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEF        = 64;
  localparam int PAYLOAD_BITS_DEF = 64;

  // Fixed field widths
  localparam int KIND_W   = 3;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_PEEK_FRONT = 3'd3,
    KIND_REVERSE    = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture the operation at the transfer
    logic exec;     // update pointers, write and read the store
    logic respond;  // present the result for one cycle
  } qfir_cmd_t;

endpackage

// ===== hdl/qfir_ctrl.sv =====
module qfir_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output qfir_pkg::qfir_cmd_t cmd_o
);
  import qfir_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o.load    = 1'b0;
    cmd_o.exec    = 1'b0;
    cmd_o.respond = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        cmd_o.respond = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ===== hdl/qfir_dp.sv =====
module qfir_dp #(
  parameter int DEPTH        = qfir_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = qfir_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  qfir_pkg::qfir_cmd_t           cmd_i,
  input  logic [qfir_pkg::KIND_W-1:0]   kind_i,
  input  logic signed [qfir_pkg::KEY_W-1:0] entry_key_i,
  input  logic [PAYLOAD_BITS-1:0]       entry_payload_i,
  output logic [qfir_pkg::STATUS_W-1:0] status_o,
  output logic signed [qfir_pkg::KEY_W-1:0] out_key_o,
  output logic [PAYLOAD_BITS-1:0]       out_payload_o,
  output logic [qfir_pkg::COUNT_W-1:0]  count_o,
  output logic                          is_empty_o
);
  import qfir_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W+1)'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // Ring store
  logic [KEY_W-1:0]        key_mem [DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_mem [DEPTH];

  // Captured operation
  logic [KIND_W-1:0]       kind_q;
  logic [KEY_W-1:0]        key_q;
  logic [PAYLOAD_BITS-1:0] pay_q;

  // Queue pointers
  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             rev_q, rev_d;

  // Result selection
  logic [STATUS_W-1:0]     status_q, status_d;
  logic                    bypass_q, bypass_d;
  logic                    zero_q, zero_d;
  logic [KEY_W-1:0]        rkey_q;
  logic [PAYLOAD_BITS-1:0] rpay_q;

  logic                    we;
  logic [IDX_W-1:0]        waddr, raddr;
  logic [CNT_W-1:0]        cnt_m1;

  // Slot of logical position pos relative to front, modulo DEPTH
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] f,
                                               input logic [IDX_W-1:0] pos,
                                               input logic rev);
    logic [IDX_W:0] s;
    begin
      if (rev) begin
        if (f >= pos) s = {1'b0, f} - {1'b0, pos};
        else          s = {1'b0, f} + DEPTH_X - {1'b0, pos};
      end else begin
        s = {1'b0, f} + {1'b0, pos};
        if (s >= DEPTH_X) s = s - DEPTH_X;
      end
      slot_of = s[IDX_W-1:0];
    end
  endfunction

  assign cnt_m1 = count_q - CNT_W'(1);

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    rev_d    = rev_q;
    status_d = STATUS_OK;
    bypass_d = 1'b0;
    we       = 1'b0;
    waddr    = front_q;
    raddr    = front_q;
    case (kind_q)
      KIND_PUSH_BACK: begin
        if (count_q == FULL_CNT) begin
          status_d = STATUS_FULL;
        end else begin
          we       = 1'b1;
          waddr    = slot_of(front_q, count_q[IDX_W-1:0], rev_q);
          count_d  = count_q + CNT_W'(1);
          bypass_d = (count_q == '0);
        end
      end
      KIND_PUSH_FRONT: begin
        if (count_q == FULL_CNT) begin
          status_d = STATUS_FULL;
        end else begin
          if (count_q != '0) begin
            if (rev_q) front_d = (front_q == LAST_IDX) ? '0 : front_q + IDX_W'(1);
            else       front_d = (front_q == '0) ? LAST_IDX : front_q - IDX_W'(1);
          end
          we       = 1'b1;
          waddr    = front_d;
          count_d  = count_q + CNT_W'(1);
          bypass_d = 1'b1;
        end
      end
      KIND_POP_FRONT, KIND_PEEK_FRONT: begin
        // read the old front in both cases
        if (count_q == '0) begin
          status_d = STATUS_EMPTY;
        end else if (kind_q == KIND_POP_FRONT) begin
          count_d = cnt_m1;
          if (cnt_m1 != '0) front_d = slot_of(front_q, IDX_W'(1), rev_q);
        end
      end
      KIND_REVERSE: begin
        if (count_q > CNT_W'(1)) begin
          front_d = slot_of(front_q, cnt_m1[IDX_W-1:0], rev_q);
          rev_d   = ~rev_q;
          raddr   = front_d;
        end
      end
      default: begin
      end
    endcase
    // a pop of the last record still reports that record
    zero_d = (status_d == STATUS_EMPTY) || ((count_q == '0) && (count_d == '0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      count_q  <= '0;
      rev_q    <= 1'b0;
      kind_q   <= '0;
      status_q <= STATUS_OK;
      bypass_q <= 1'b0;
      zero_q   <= 1'b1;
    end else begin
      if (cmd_i.load) begin
        kind_q <= kind_i;
      end
      if (cmd_i.exec) begin
        front_q  <= front_d;
        count_q  <= count_d;
        rev_q    <= rev_d;
        status_q <= status_d;
        bypass_q <= bypass_d;
        zero_q   <= zero_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= entry_key_i;
      pay_q <= entry_payload_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) begin
      key_mem[waddr] <= key_q;
      pay_mem[waddr] <= pay_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rkey_q <= key_mem[raddr];
      rpay_q <= pay_mem[raddr];
    end
  end

  always_comb begin
    if (zero_q) begin
      out_key_o     = '0;
      out_payload_o = '0;
    end else if (bypass_q) begin
      out_key_o     = key_q;
      out_payload_o = pay_q;
    end else begin
      out_key_o     = rkey_q;
      out_payload_o = rpay_q;
    end
  end

  assign status_o   = status_q;
  assign count_o    = COUNT_W'(count_q);
  assign is_empty_o = (count_q == '0);

endmodule

// ===== hdl/queue_front_insert_reverse.sv =====
// Channel   Direction  Handshake                 Payload
// command   in         start_i, busy_o           kind_i, entry_key_i, entry_payload_i
// result    out        done_o (one-cycle strobe) status_o, out_key_o, out_payload_o,
//                                                count_o, is_empty_o
//
// A command transfers on a rising edge with start_i high and busy_o low.
// Each command runs through capture, one store access (write of the
// pushed record and registered read of the front), then the result strobe.
// rst_ni clears the pointers, count and direction flag; the store is not cleared.
// The receiver cannot stall: done_o is high for exactly one cycle per command.
module queue_front_insert_reverse #(
  parameter int DEPTH        = qfir_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = qfir_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [qfir_pkg::KIND_W-1:0]   kind_i,
  input  logic signed [qfir_pkg::KEY_W-1:0] entry_key_i,
  input  logic [PAYLOAD_BITS-1:0]       entry_payload_i,
  output logic                          done_o,
  output logic [qfir_pkg::STATUS_W-1:0] status_o,
  output logic signed [qfir_pkg::KEY_W-1:0] out_key_o,
  output logic [PAYLOAD_BITS-1:0]       out_payload_o,
  output logic [qfir_pkg::COUNT_W-1:0]  count_o,
  output logic                          is_empty_o
);
  import qfir_pkg::*;

  qfir_cmd_t cmd;

  // Sequence each command: capture, execute, respond
  qfir_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  // Ring store, head index, count and direction flag
  qfir_dp #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .kind_i          (kind_i),
    .entry_key_i     (entry_key_i),
    .entry_payload_i (entry_payload_i),
    .status_o        (status_o),
    .out_key_o       (out_key_o),
    .out_payload_o   (out_payload_o),
    .count_o         (count_o),
    .is_empty_o      (is_empty_o)
  );

  // Strobe the result in the respond cycle
  assign done_o = cmd.respond;

endmodule

// ===== test/tb.sv =====
module tb;
  import qfir_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int PB = PAYLOAD_BITS_DEF;
  // Kind codes 5 to 7 carry no operation; the block answers them like a no-op.
  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST = 3'd7;
  // Cycles without any transfer on either side before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Cycles to wait after the last result.
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1650;

  typedef struct packed {
    status_e status;
    logic signed [KEY_W-1:0] key;
    logic [PB-1:0] payload;
    logic [COUNT_W-1:0] count;
    logic is_empty;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [KIND_W-1:0] kind_i = '0;
  logic signed [KEY_W-1:0] entry_key_i = '0;
  logic [PB-1:0] entry_payload_i = '0;
  logic busy_o;
  logic done_o;
  logic [STATUS_W-1:0] status_o;
  logic signed [KEY_W-1:0] out_key_o;
  logic [PB-1:0] out_payload_o;
  logic [COUNT_W-1:0] count_o;
  logic is_empty_o;

  queue_front_insert_reverse #(
    .DEPTH(DEPTH),
    .PAYLOAD_BITS(PB)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .kind_i(kind_i),
    .entry_key_i(entry_key_i),
    .entry_payload_i(entry_payload_i),
    .done_o(done_o),
    .status_o(status_o),
    .out_key_o(out_key_o),
    .out_payload_o(out_payload_o),
    .count_o(count_o),
    .is_empty_o(is_empty_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow copy of the deque: ring store, front slot, record count and the
  // direction flag. Logical position i lives at front+i, or front-i when the
  // order has been flipped.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0] shadow_key[DEPTH];
  logic [PB-1:0] shadow_payload[DEPTH];
  int unsigned front_slot = 0;
  int unsigned held_cnt = 0;
  bit flipped = 1'b0;

  result_t expected_results[$];
  int error_cnt = 0;
  bit gaps_on = 1'b1;
  result_t want;

  function automatic int unsigned slot_at(int unsigned pos);
    if (flipped) begin
      return (front_slot + DEPTH - (pos % DEPTH)) % DEPTH;
    end
    return (front_slot + (pos % DEPTH)) % DEPTH;
  endfunction

  // Apply one operation to the shadow deque and return the result it must give.
  function automatic result_t apply_queue_op(logic [KIND_W-1:0] kind,
                                             logic [KEY_W-1:0] key,
                                             logic [PB-1:0] payload);
    result_t res;
    bit have_rec;
    int unsigned s;
    res = '0;
    res.status = STATUS_OK;
    have_rec = 1'b0;
    case (kind)
      KIND_PUSH_BACK: begin
        if (held_cnt >= DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          s = slot_at(held_cnt);
          shadow_key[s] = key;
          shadow_payload[s] = payload;
          held_cnt++;
        end
      end
      KIND_PUSH_FRONT: begin
        if (held_cnt >= DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          // step the front one slot against the current direction
          if (held_cnt != 0) begin
            front_slot = flipped ? (front_slot + 1) % DEPTH
                                 : (front_slot + DEPTH - 1) % DEPTH;
          end
          shadow_key[front_slot] = key;
          shadow_payload[front_slot] = payload;
          held_cnt++;
        end
      end
      KIND_POP_FRONT, KIND_PEEK_FRONT: begin
        if (held_cnt == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.key = shadow_key[front_slot];
          res.payload = shadow_payload[front_slot];
          have_rec = 1'b1;
          if (kind == KIND_POP_FRONT) begin
            held_cnt--;
            if (held_cnt != 0) front_slot = slot_at(1);
          end
        end
      end
      KIND_REVERSE: begin
        // the back record becomes the front and the walk direction flips
        if (held_cnt > 1) begin
          front_slot = slot_at(held_cnt - 1);
          flipped = ~flipped;
        end
      end
      default: ;
    endcase
    if (!have_rec && res.status != STATUS_EMPTY && held_cnt != 0) begin
      res.key = shadow_key[front_slot];
      res.payload = shadow_payload[front_slot];
    end
    res.count = held_cnt[COUNT_W-1:0];
    res.is_empty = (held_cnt == 0);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Command side. Hold start_i high with the fields until the transfer, then
  // record the expected result. start_i stays high when the next command
  // follows at once, so it is never lowered and raised in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                         input logic [PB-1:0] payload);
    start_i <= 1'b1;
    kind_i <= kind;
    entry_key_i <= key;
    entry_payload_i <= payload;
    do @(posedge clk_i); while (busy_o);
    expected_results.push_back(apply_queue_op(kind, key, payload));
    idle_gap();
  endtask

  // Drop start_i for a random gap: mostly none or short, now and then long.
  task automatic idle_gap();
    int unsigned roll;
    int unsigned len;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 50) begin
      len = 0;
    end else if (roll < 90) begin
      len = $urandom_range(1, 3);
    end else begin
      len = $urandom_range(4, 30);
    end
    if (len != 0) begin
      start_i <= 1'b0;
      repeat (len) @(posedge clk_i);
    end
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [PB-1:0] rand_payload();
    logic [63:0] wide;
    case ($urandom_range(0, 9))
      0: wide = '0;
      1: wide = '1;
      default: wide = {$urandom, $urandom};
    endcase
    return wide[PB-1:0];
  endfunction

  // Pick a kind; grow favors pushes, drain favors pops, mix spreads them.
  function automatic logic [KIND_W-1:0] pick_kind(int unsigned mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
    case (mode)
      0: begin
        if (r < 45) return KIND_PUSH_BACK;
        if (r < 75) return KIND_PUSH_FRONT;
        if (r < 83) return KIND_POP_FRONT;
        if (r < 92) return KIND_PEEK_FRONT;
        return KIND_REVERSE;
      end
      1: begin
        if (r < 20) return KIND_PUSH_BACK;
        if (r < 35) return KIND_PUSH_FRONT;
        if (r < 75) return KIND_POP_FRONT;
        if (r < 88) return KIND_PEEK_FRONT;
        return KIND_REVERSE;
      end
      default: begin
        if (r < 25) return KIND_PUSH_BACK;
        if (r < 45) return KIND_PUSH_FRONT;
        if (r < 65) return KIND_POP_FRONT;
        if (r < 80) return KIND_PEEK_FRONT;
        return KIND_REVERSE;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: every done_o strobe is one transfer; compare it field by
  // field with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result with none expected: status %0d key %0d count %0d",
               status_o, out_key_o, count_o);
        error_cnt++;
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          error_cnt++;
        end
        if (out_key_o !== want.key) begin
          $error("out_key: expected %0d, got %0d", want.key, out_key_o);
          error_cnt++;
        end
        if (out_payload_o !== want.payload) begin
          $error("out_payload: expected %h, got %h", want.payload, out_payload_o);
          error_cnt++;
        end
        if (count_o !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, count_o);
          error_cnt++;
        end
        if (is_empty_o !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty, is_empty_o);
          error_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run once nothing has transferred for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || done_o) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pop, peek and reverse on an empty queue, plus the spare kinds.
  task automatic test_empty_queue();
    send_op(KIND_POP_FRONT, rand_key(), rand_payload());
    send_op(KIND_PEEK_FRONT, rand_key(), rand_payload());
    send_op(KIND_REVERSE, rand_key(), rand_payload());
    for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) begin
      send_op(k[KIND_W-1:0], rand_key(), rand_payload());
    end
  endtask

  // Extreme keys and payloads through every operation, reverse of one record
  // and of several, a spare kind with records held, then drain to empty.
  task automatic test_directed_records();
    send_op(KIND_PUSH_BACK, 32'h7FFF_FFFF, '1);
    send_op(KIND_PEEK_FRONT, '0, '0);
    send_op(KIND_REVERSE, '0, '0);
    send_op(KIND_PUSH_FRONT, 32'h8000_0000, '0);
    send_op(KIND_PUSH_BACK, '0, {(PB/2){2'b01}});
    send_op(KIND_PEEK_FRONT, '1, '1);
    send_op(KIND_REVERSE, '0, '0);
    send_op(KIND_PEEK_FRONT, '0, '0);
    send_op(KIND_PUSH_FRONT, '1, {(PB/2){2'b10}});
    send_op(KIND_PUSH_BACK, 32'h5A5A_A5A5, '1);
    send_op(KIND_REVERSE, '0, '0);
    send_op(KIND_SPARE_FIRST, '1, '1);
    send_op(KIND_POP_FRONT, '0, '0);
    send_op(KIND_PUSH_FRONT, 32'h0000_0001, 64'h1);
    send_op(KIND_POP_FRONT, '0, '0);
    send_op(KIND_POP_FRONT, '0, '0);
    send_op(KIND_REVERSE, '0, '0);
    send_op(KIND_POP_FRONT, '0, '0);
    send_op(KIND_POP_FRONT, '0, '0);
    send_op(KIND_POP_FRONT, '0, '0);
  endtask

  // Fill to capacity from both ends, push into the full queue, reverse it,
  // then pop everything back out.
  task automatic test_full_queue();
    while (held_cnt < DEPTH) begin
      send_op($urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK,
              rand_key(), rand_payload());
    end
    send_op(KIND_PUSH_BACK, rand_key(), rand_payload());
    send_op(KIND_PUSH_FRONT, rand_key(), rand_payload());
    send_op(KIND_REVERSE, '0, '0);
    send_op(KIND_PEEK_FRONT, '0, '0);
    send_op(KIND_SPARE_LAST, rand_key(), rand_payload());
    send_op(KIND_PUSH_FRONT, rand_key(), rand_payload());
    while (held_cnt > 0) begin
      send_op(KIND_POP_FRONT, rand_key(), rand_payload());
    end
    send_op(KIND_POP_FRONT, rand_key(), rand_payload());
  endtask

  // Phases of growing, draining and mixed traffic with random content; some
  // phases run back to back with no gaps at all.
  task automatic test_random_traffic();
    int items_left;
    int unsigned mode;
    int unsigned phase_len;
    items_left = RANDOM_ITEMS;
    while (items_left > 0) begin
      mode = $urandom_range(0, 2);
      phase_len = $urandom_range(20, 120);
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < phase_len && items_left > 0; i++) begin
        send_op(pick_kind(mode), rand_key(), rand_payload());
        items_left--;
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_directed_records();
    test_full_queue();
    test_random_traffic();

    // release the command side, wait out every result, then settle
    start_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/qfir_pkg.sv
hdl/qfir_ctrl.sv
hdl/qfir_dp.sv
hdl/queue_front_insert_reverse.sv
test/tb.sv
